// File: rtl/pngc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pngc_pkg;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_STOP = 6'b100000
  } phase_t;

  // Section codes
  localparam logic [2:0] SEC_SIG  = 3'd0;
  localparam logic [2:0] SEC_LEN  = 3'd1;
  localparam logic [2:0] SEC_TYPE = 3'd2;
  localparam logic [2:0] SEC_DATA = 3'd3;
  localparam logic [2:0] SEC_CRC  = 3'd4;

  // Chunk kinds
  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_IHDR  = 3'd1;
  localparam logic [2:0] KIND_PLTE  = 3'd2;
  localparam logic [2:0] KIND_TRNS  = 3'd3;
  localparam logic [2:0] KIND_IDAT  = 3'd4;
  localparam logic [2:0] KIND_IEND  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_SIG  = 3'd2;
  localparam logic [2:0] ST_BAD_CRC  = 3'd3;
  localparam logic [2:0] ST_DUP      = 3'd4;
  localparam logic [2:0] ST_BAD_FMT  = 3'd5;
  localparam logic [2:0] ST_STOPPED  = 3'd6;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

  localparam logic [31:0] TYPE_IHDR = 32'h49484452;
  localparam logic [31:0] TYPE_PLTE = 32'h504C5445;
  localparam logic [31:0] TYPE_TRNS = 32'h74524E53;
  localparam logic [31:0] TYPE_IDAT = 32'h49444154;
  localparam logic [31:0] TYPE_IEND = 32'h49454E44;

  // Seen-mark bits
  localparam int unsigned MARK_IHDR = 0;
  localparam int unsigned MARK_PLTE = 1;
  localparam int unsigned MARK_TRNS = 2;

  typedef struct packed {
    logic [2:0] section;
    logic [2:0] kind;
    logic       chunk_end;
    logic [2:0] status;
  } pngc_res_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'd137;
      3'd1: v = 8'd80;
      3'd2: v = 8'd78;
      3'd3: v = 8'd71;
      3'd4: v = 8'd13;
      3'd5: v = 8'd10;
      3'd6: v = 8'd26;
      3'd7: v = 8'd10;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // One byte of reflected CRC-32, eight bit steps unrolled into XORs
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, r[31:1]} ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [2:0] kind_of(input logic [31:0] t);
    logic [2:0] k;
    if (t == TYPE_IHDR) k = KIND_IHDR;
    else if (t == TYPE_PLTE) k = KIND_PLTE;
    else if (t == TYPE_TRNS) k = KIND_TRNS;
    else if (t == TYPE_IDAT) k = KIND_IDAT;
    else if (t == TYPE_IEND) k = KIND_IEND;
    else k = KIND_OTHER;
    return k;
  endfunction

  // depth, color, compression, filter, interlace from the high byte down
  function automatic logic format_ok(input logic [39:0] f);
    logic ok;
    ok = 1'b0;
    if (f[23:0] == 24'd0) begin
      if (f[39:32] == 8'd8) begin
        case (f[31:24]) inside
          8'd0, 8'd2, 8'd3, 8'd4, 8'd6: ok = 1'b1;
          default: ok = 1'b0;
        endcase
      end else if (f[39:32] == 8'd16) begin
        case (f[31:24]) inside
          8'd0, 8'd2, 8'd4, 8'd6: ok = 1'b1;
          default: ok = 1'b0;
        endcase
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pngc_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module pngc_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [7:0]          in_byte,
  input  wire logic                start_file,
  output pngc_pkg::pngc_res_t      res
);

  pngc_pkg::phase_t phase_r, phase_nxt, cur_phase;
  logic [31:0] byte_count_r, byte_count_nxt, cur_bc;
  logic [31:0] chunk_length_r, chunk_length_nxt;
  logic [31:0] running_crc_r, running_crc_nxt;
  logic [31:0] stored_crc_r, stored_crc_nxt;
  logic [31:0] type_bytes_r, type_bytes_nxt;
  logic [2:0]  seen_r, seen_nxt, cur_seen;
  logic [39:0] hdr_fmt_r, hdr_fmt_nxt, cur_fmt;
  logic        sig_bad_r, sig_bad_nxt, cur_sig_bad;
  logic [2:0]  mark;
  logic [2:0]  cur_kind;

  // A start mark acts as a clear in front of this byte
  always_comb begin
    cur_phase   = start_file ? pngc_pkg::PH_SIG : phase_r;
    cur_bc      = start_file ? 32'd0 : byte_count_r;
    cur_seen    = start_file ? 3'd0 : seen_r;
    cur_fmt     = start_file ? 40'd0 : hdr_fmt_r;
    cur_sig_bad = start_file ? 1'b0 : sig_bad_r;
    cur_kind    = pngc_pkg::kind_of(type_bytes_r);
  end

  always_comb begin
    phase_nxt        = cur_phase;
    byte_count_nxt   = cur_bc;
    chunk_length_nxt = chunk_length_r;
    running_crc_nxt  = running_crc_r;
    stored_crc_nxt   = stored_crc_r;
    type_bytes_nxt   = type_bytes_r;
    seen_nxt         = cur_seen;
    hdr_fmt_nxt      = cur_fmt;
    sig_bad_nxt      = cur_sig_bad;
    mark             = 3'd0;
    res.section      = pngc_pkg::SEC_SIG;
    res.kind         = pngc_pkg::KIND_OTHER;
    res.chunk_end    = 1'b0;
    res.status       = pngc_pkg::ST_RUNNING;

    unique case (cur_phase)
      pngc_pkg::PH_SIG: begin
        res.section = pngc_pkg::SEC_SIG;
        if (in_byte != pngc_pkg::sig_byte(cur_bc[2:0])) sig_bad_nxt = 1'b1;
        if (cur_bc >= 32'd7) begin
          res.chunk_end  = 1'b1;
          byte_count_nxt = 32'd0;
          if (sig_bad_nxt) begin
            res.status = pngc_pkg::ST_BAD_SIG;
            phase_nxt  = pngc_pkg::PH_STOP;
          end else begin
            phase_nxt = pngc_pkg::PH_LEN;
          end
        end else begin
          byte_count_nxt = cur_bc + 32'd1;
        end
      end
      pngc_pkg::PH_LEN: begin
        res.section      = pngc_pkg::SEC_LEN;
        chunk_length_nxt = {chunk_length_r[23:0], in_byte};
        if (cur_bc >= 32'd3) begin
          byte_count_nxt  = 32'd0;
          type_bytes_nxt  = 32'd0;
          running_crc_nxt = pngc_pkg::CRC_PRESET;
          phase_nxt       = pngc_pkg::PH_TYPE;
        end else begin
          byte_count_nxt = cur_bc + 32'd1;
        end
      end
      pngc_pkg::PH_TYPE: begin
        res.section     = pngc_pkg::SEC_TYPE;
        type_bytes_nxt  = {type_bytes_r[23:0], in_byte};
        running_crc_nxt = pngc_pkg::crc_byte(running_crc_r, in_byte);
        res.kind        = pngc_pkg::kind_of(type_bytes_nxt);
        if (cur_bc >= 32'd3) begin
          byte_count_nxt = 32'd0;
          stored_crc_nxt = 32'd0;
          phase_nxt = (chunk_length_r == 32'd0) ? pngc_pkg::PH_CRC : pngc_pkg::PH_DATA;
        end else begin
          byte_count_nxt = cur_bc + 32'd1;
        end
      end
      pngc_pkg::PH_DATA: begin
        res.section     = pngc_pkg::SEC_DATA;
        res.kind        = cur_kind;
        running_crc_nxt = pngc_pkg::crc_byte(running_crc_r, in_byte);
        // IHDR data bytes 8..12 hold the format fields, first IHDR only
        if (cur_kind == pngc_pkg::KIND_IHDR && !cur_seen[pngc_pkg::MARK_IHDR] &&
            cur_bc[31:4] == 28'd0) begin
          case (cur_bc[3:0])
            4'd8:  hdr_fmt_nxt[39:32] = in_byte;
            4'd9:  hdr_fmt_nxt[31:24] = in_byte;
            4'd10: hdr_fmt_nxt[23:16] = in_byte;
            4'd11: hdr_fmt_nxt[15:8]  = in_byte;
            4'd12: hdr_fmt_nxt[7:0]   = in_byte;
            default: hdr_fmt_nxt = cur_fmt;
          endcase
        end
        if (cur_bc >= chunk_length_r - 32'd1) begin
          byte_count_nxt = 32'd0;
          phase_nxt      = pngc_pkg::PH_CRC;
        end else begin
          byte_count_nxt = cur_bc + 32'd1;
        end
      end
      pngc_pkg::PH_CRC: begin
        res.section    = pngc_pkg::SEC_CRC;
        res.kind       = cur_kind;
        stored_crc_nxt = {stored_crc_r[23:0], in_byte};
        if (cur_bc >= 32'd3) begin
          res.chunk_end    = 1'b1;
          byte_count_nxt   = 32'd0;
          chunk_length_nxt = 32'd0;
          case (cur_kind)
            pngc_pkg::KIND_IHDR: mark = 3'b001;
            pngc_pkg::KIND_PLTE: mark = 3'b010;
            pngc_pkg::KIND_TRNS: mark = 3'b100;
            default:             mark = 3'b000;
          endcase
          if ((running_crc_r ^ pngc_pkg::CRC_PRESET) != stored_crc_nxt)
            res.status = pngc_pkg::ST_BAD_CRC;
          else if ((cur_seen & mark) != 3'd0)
            res.status = pngc_pkg::ST_DUP;
          else if (cur_kind == pngc_pkg::KIND_IDAT &&
                   (!cur_seen[pngc_pkg::MARK_IHDR] || !pngc_pkg::format_ok(cur_fmt)))
            res.status = pngc_pkg::ST_BAD_FMT;
          else if (cur_kind == pngc_pkg::KIND_IEND)
            res.status = pngc_pkg::ST_COMPLETE;
          if (res.status != pngc_pkg::ST_RUNNING) begin
            phase_nxt = pngc_pkg::PH_STOP;
          end else begin
            seen_nxt  = cur_seen | mark;
            phase_nxt = pngc_pkg::PH_LEN;
          end
        end else begin
          byte_count_nxt = cur_bc + 32'd1;
        end
      end
      default: begin
        res.status = pngc_pkg::ST_STOPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pngc_pkg::PH_STOP;
    end else if (acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      byte_count_r   <= byte_count_nxt;
      chunk_length_r <= chunk_length_nxt;
      running_crc_r  <= running_crc_nxt;
      stored_crc_r   <= stored_crc_nxt;
      type_bytes_r   <= type_bytes_nxt;
      seen_r         <= seen_nxt;
      hdr_fmt_r      <= hdr_fmt_nxt;
      sig_bad_r      <= sig_bad_nxt;
    end
  end

  a_verdict_stops: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.status != pngc_pkg::ST_RUNNING && res.status != pngc_pkg::ST_STOPPED
    |=> phase_r == pngc_pkg::PH_STOP)
    else $error("verdict did not stop the parser");

  a_clean_end_next_len: assert property (@(posedge clk) disable iff (!rst_n)
    acc && res.chunk_end && res.status == pngc_pkg::ST_RUNNING
    |=> phase_r == pngc_pkg::PH_LEN)
    else $error("clean chunk end did not return to length");

  a_sig_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == pngc_pkg::PH_SIG |-> byte_count_r < 32'd8)
    else $error("signature byte count out of range");

endmodule

`default_nettype wire

// File: rtl/png_chunk_stream_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// PNG chunk stream checker.
// Input stream: one file byte per item on in_tdata; in_tuser high marks the
// first byte of a new file and clears all parse state.
// Output stream: one item per input item, the byte passed through with its
// section, chunk kind and status; out_tlast flags the last signature byte
// and the last stored-checksum byte of each chunk, where verdicts appear.
// out_tvalid rises in the cycle after input accept. Throughput is one item
// per cycle while out_tready stays high; the CRC-32 byte update is an unrolled
// XOR network next to the phase logic, so nothing iterates.
// After reset the block is stopped: items are accepted and answered with
// status stopped until an item arrives with in_tuser set. Any verdict
// (complete or an error) stops it again the same way.
// A single output register separates the two sides: while it holds an item
// that the receiver has not taken, in_tready stays low unless out_tready is
// high in that cycle, so a new item is accepted whenever the slot drains.
module png_chunk_stream_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] in_byte
  input  wire logic        in_tuser,   // [0] start_file
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic [5:0]       out_tuser,  // [2:0] section, [5:3] chunk_kind
  output logic             out_tlast   // chunk_end
);

  logic                in_fire;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  pngc_pkg::pngc_res_t res;
  pngc_pkg::pngc_res_t res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  pngc_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_fire),
    .in_byte    (in_tdata),
    .start_file (in_tuser),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte_r <= in_tdata;
      res_r      <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.status, out_byte_r};
  assign out_tuser  = {res_r.kind, res_r.section};
  assign out_tlast  = res_r.chunk_end;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  a_empty_slot_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_complete_at_chunk_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:8] == pngc_pkg::ST_COMPLETE
    |-> out_tlast && out_tuser[2:0] == pngc_pkg::SEC_CRC)
    else $error("complete status outside a checksum chunk end");

endmodule

`default_nettype wire
